// ===== rtl/salts_pkg.sv =====
// ----------------------------------------------------------------------------
// salts_pkg
// shared types and constants of the set-associative tag store with
// timestamp lru replacement
// ----------------------------------------------------------------------------
package salts_pkg;

    localparam int unsigned ADDRESS_W     = 32;
    localparam int unsigned STAMP_W       = 32;
    localparam int unsigned LINE_INDEX_W  = 8;

    localparam int unsigned NUM_SETS_DEF  = 64;
    localparam int unsigned NUM_WAYS_DEF  = 4;
    localparam int unsigned ADDR_BITS_DEF = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [ADDRESS_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic [LINE_INDEX_W-1:0] line_index;
        logic                    evicted_valid;
        logic [ADDRESS_W-1:0]    evicted_address;
        logic                    duplicate;
    } rsp_t;

endpackage

// ===== rtl/salts_ram.sv =====
// ----------------------------------------------------------------------------
// salts_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module salts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/set_associative_lru_tag_store.sv =====
// flow: a request goes straight to S_EVAL when NUM_SETS is a power of two,
//   else via S_DIV, S_MOD and S_READ (set remainder by reciprocal multiply
//   and correction); S_EVAL registers the result, and requests stall until the
//   read-modify-write of one set row in the tag ram is done; a stalled result
//   delays the next one. reset: a clearing pass zeroes every set row while
//   requests are stalled; the access counter resets to zero
// ----------------------------------------------------------------------------
// set_associative_lru_tag_store
// set-associative tag store with timestamp lru; one ram row holds a whole set
// ----------------------------------------------------------------------------
module set_associative_lru_tag_store #(
    parameter int unsigned NUM_SETS  = salts_pkg::NUM_SETS_DEF,
    parameter int unsigned NUM_WAYS  = salts_pkg::NUM_WAYS_DEF,
    parameter int unsigned ADDR_BITS = salts_pkg::ADDR_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  salts_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output salts_pkg::rsp_t rsp
);

    import salts_pkg::*;

    localparam int unsigned SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned TREE_N     = 2 ** WAY_W;
    localparam int unsigned ADDR_EXT_W = (ADDR_BITS > SET_W) ? ADDR_BITS : SET_W;
    localparam int unsigned IDX_FULL_W = $clog2(NUM_SETS * NUM_WAYS + 1);
    localparam int unsigned IDX_W      = (IDX_FULL_W > LINE_INDEX_W) ? IDX_FULL_W
                                                                     : LINE_INDEX_W;
    localparam int unsigned ROW_W      = NUM_WAYS * (1 + ADDR_BITS + STAMP_W);
    localparam bit          SETS_POW2  = ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);
    localparam logic [ADDRESS_W-1:0] RECIP =
        ADDRESS_W'((64'd1 << ADDRESS_W) / 64'(NUM_SETS));

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_MOD   = 6'b001000,
        S_READ  = 6'b010000,
        S_EVAL  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SET_W-1:0]       set_reg, set_next;
    logic [ADDRESS_W-1:0]   quot_reg, quot_next;
    logic                   op_reg, op_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [STAMP_W-1:0]     cnt_reg, cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   req_xfer;
    logic                   eval_fire;
    logic [ADDR_BITS-1:0]   addr_in;
    logic [ADDR_EXT_W-1:0]  addr_ext;
    logic [SET_W-1:0]       set_pow2;
    logic [ADDRESS_W-1:0]   div_x;
    logic [2*ADDRESS_W-1:0] quot_prod;
    logic [ADDRESS_W-1:0]   rem_est;
    logic [ADDRESS_W-1:0]   rem_fix;

    logic                   mem_we;
    logic                   mem_re;
    logic [SET_W-1:0]       mem_raddr;
    logic [ROW_W-1:0]       mem_wdata;
    logic [ROW_W-1:0]       mem_rdata;

    logic [NUM_WAYS-1:0]                row_valid;
    logic [NUM_WAYS-1:0][ADDR_BITS-1:0] row_addr;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   row_stamp;
    logic [NUM_WAYS-1:0]                new_valid;
    logic [NUM_WAYS-1:0][ADDR_BITS-1:0] new_addr;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]   new_stamp;

    logic [NUM_WAYS-1:0]    match;
    logic                   hit_any;
    logic [WAY_W-1:0]       hit_way;
    logic                   free_any;
    logic [WAY_W-1:0]       free_way;
    logic [WAY_W-1:0]       lru_way;
    logic [WAY_W-1:0]       victim;
    logic [WAY_W-1:0]       way_sel;
    logic [IDX_W-1:0]       idx_full;
    logic [STAMP_W-1:0]     cnt_inc;
    logic                   row_we;

    logic [WAY_W-1:0]       node_way   [1:2*TREE_N-1];
    logic [STAMP_W-1:0]     node_stamp [1:2*TREE_N-1];
    logic                   node_pad   [1:2*TREE_N-1];

    // request side
    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign addr_in   = ADDR_BITS'(req.address);
    assign addr_ext  = ADDR_EXT_W'(addr_in);
    assign set_pow2  = addr_ext[SET_W-1:0] & SET_MASK;

    // set remainder by reciprocal multiply and one correction
    assign div_x     = ADDRESS_W'(addr_reg);
    assign quot_prod = (2*ADDRESS_W)'(div_x) * (2*ADDRESS_W)'(RECIP);
    assign rem_est   = div_x - quot_reg * ADDRESS_W'(NUM_SETS);
    assign rem_fix   = (rem_est >= ADDRESS_W'(NUM_SETS))
                     ? rem_est - ADDRESS_W'(NUM_SETS) : rem_est;

    assign eval_fire = (state_reg == S_EVAL) && (!rsp_valid_reg || !rsp_stall);

    // set row layout
    assign {row_valid, row_addr, row_stamp} = mem_rdata;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match[w] = row_valid[w] && (row_addr[w] == addr_reg);
        end
        hit_any  = |match;
        free_any = ~&row_valid;
        hit_way  = '0;
        free_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!row_valid[w])
            begin
                free_way = WAY_W'(w);
            end
        end
    end

    // oldest-stamp tree, lower way wins a tie
    always_comb
    begin
        for (int w = 0; w < TREE_N; w++)
        begin
            node_way[TREE_N + w] = WAY_W'(w);
            if (w < NUM_WAYS)
            begin
                node_stamp[TREE_N + w] = row_stamp[w];
                node_pad[TREE_N + w]   = 1'b0;
            end
            else
            begin
                node_stamp[TREE_N + w] = '0;
                node_pad[TREE_N + w]   = 1'b1;
            end
        end
        for (int i = TREE_N - 1; i >= 1; i--)
        begin
            if (!node_pad[2*i+1]
                && (node_pad[2*i] || (node_stamp[2*i+1] < node_stamp[2*i])))
            begin
                node_way[i]   = node_way[2*i+1];
                node_stamp[i] = node_stamp[2*i+1];
                node_pad[i]   = node_pad[2*i+1];
            end
            else
            begin
                node_way[i]   = node_way[2*i];
                node_stamp[i] = node_stamp[2*i];
                node_pad[i]   = node_pad[2*i];
            end
        end
        lru_way = node_way[1];
    end

    assign victim   = free_any ? free_way : lru_way;
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + STAMP_W'(1);
    assign way_sel  = ((op_reg == OP_READ) || hit_any) ? hit_way : victim;
    assign idx_full = IDX_W'(set_reg) * IDX_W'(NUM_WAYS) + IDX_W'(way_sel);

    // row update and result
    always_comb
    begin
        new_valid = row_valid;
        new_addr  = row_addr;
        new_stamp = row_stamp;
        row_we    = 1'b0;
        rsp_next  = '0;
        if (op_reg == OP_READ)
        begin
            if (hit_any)
            begin
                new_stamp[hit_way]  = cnt_inc;
                row_we              = 1'b1;
                rsp_next.hit        = 1'b1;
                rsp_next.line_index = idx_full[LINE_INDEX_W-1:0];
            end
        end
        else if (hit_any)
        begin
            rsp_next.duplicate  = 1'b1;
            rsp_next.line_index = idx_full[LINE_INDEX_W-1:0];
        end
        else
        begin
            new_valid[victim]   = 1'b1;
            new_addr[victim]    = addr_reg;
            new_stamp[victim]   = cnt_reg;
            row_we              = 1'b1;
            rsp_next.line_index = idx_full[LINE_INDEX_W-1:0];
            if (row_valid[victim])
            begin
                rsp_next.evicted_valid   = 1'b1;
                rsp_next.evicted_address = ADDRESS_W'(row_addr[victim]);
            end
        end
    end

    // ram ports
    assign mem_re    = (req_xfer && SETS_POW2) || (state_reg == S_READ);
    assign mem_raddr = (state_reg == S_IDLE) ? set_pow2 : set_reg;
    assign mem_we    = (state_reg == S_CLEAR) || (eval_fire && row_we);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : {new_valid, new_addr, new_stamp};

    salts_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS),
        .AW    (SET_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (set_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        quot_next      = quot_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                if (set_reg == SET_LAST)
                begin
                    set_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    set_next = set_reg + SET_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next   = req.operation;
                    addr_next = addr_in;
                    if (SETS_POW2)
                    begin
                        set_next   = set_pow2;
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        set_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                quot_next  = quot_prod[2*ADDRESS_W-1:ADDRESS_W];
                state_next = S_MOD;
            end
            S_MOD:
            begin
                set_next   = rem_fix[SET_W-1:0];
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (eval_fire)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg == OP_READ)
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            set_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            set_reg       <= set_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        op_reg   <= op_next;
        addr_reg <= addr_next;
        if (eval_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EVAL))
        else $error("result appeared without an evaluation step");

    a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("tag ram read and write in the same cycle");

    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg >= $past(cnt_reg))
        else $error("access counter went backward");

    a_clear_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !mem_re)
        else $error("tag ram read during clearing pass");

    a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.duplicate && (rsp_reg.evicted_valid || rsp_reg.hit)))
        else $error("duplicate result also reports hit or eviction");

endmodule
